// ===== design/tkas_pkg.sv =====
// Package for top_k_argmax_select: state type, register indexes and constants.
package tkas_pkg;

    localparam int unsigned DEF_MAX_ELEMENTS = 1024;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned INDEX_W   = 10;
    localparam int unsigned TOPCNT_W  = 7;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT = 1'b1;

    localparam logic                MODE_TOPK   = 1'b0;
    localparam logic                MODE_ARGMAX = 1'b1;

    localparam logic [TOPCNT_W-1:0] MAX_PASSES  = 7'd64;
    localparam logic [TOPCNT_W-1:0] RESET_TOPCNT = 7'd1;

    localparam logic signed [VALUE_W-1:0] INT_FLOOR = -32'sd33554432;
    localparam logic signed [VALUE_W-1:0] FIX_FLOOR = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

// ===== design/tkas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tkas_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/top_k_argmax_select_top.sv =====
// Top-k / argmax selection over a stored vector, scanned by one shared comparator.
// Load: one element per cycle, no stall, until the element with last set.
// Each selection pass then scans the N stored elements and hands over its result
// transaction; passes = 1 (argmax) or top_count clamped to 1..64 (top-k).
// Input stalls from the last element until the final result is taken.
// Reset (synchronous, active low) clears control state; the element RAM is not cleared.
module top_k_argmax_select_top
    import tkas_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DAT_W-1:0]       i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [INDEX_W-1:0]         o_index,
    output logic                       o_last_res
);

    localparam int unsigned AW = $clog2(MAX_ELEMENTS);
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ELEMENTS);

    t_state                     r_state, n_state;
    logic                       r_mode;
    logic [TOPCNT_W-1:0]        r_top_count;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_scan_addr, n_scan_addr;
    logic                       r_rd_vld, n_rd_vld;
    logic [AW-1:0]              r_rd_idx, n_rd_idx;
    logic [AW-1:0]              r_chosen, n_chosen;
    logic signed [VALUE_W-1:0]  r_best, n_best;
    logic [TOPCNT_W-1:0]        r_left, n_left;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [VALUE_W-1:0]         ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic signed [VALUE_W-1:0]  ram_rdata;

    logic                       in_acc;
    logic                       out_acc;
    logic [TOPCNT_W-1:0]        passes;
    logic signed [VALUE_W-1:0]  run_floor;
    logic [INDEX_W+AW-1:0]      index_ext;

    tkas_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_comb begin
        if (r_top_count == '0) begin
            passes = TOPCNT_W'(1);
        end else if (r_top_count > MAX_PASSES) begin
            passes = MAX_PASSES;
        end else begin
            passes = r_top_count;
        end
    end

    assign run_floor = (r_mode == MODE_ARGMAX) ? INT_FLOOR : FIX_FLOOR;
    assign index_ext = {{INDEX_W{1'b0}}, r_chosen};

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_index     = index_ext[INDEX_W-1:0];
    assign o_last_res  = (r_left == TOPCNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan_addr = r_scan_addr;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_chosen    = r_chosen;
        n_best      = r_best;
        n_left      = r_left;
        ram_we      = 1'b0;
        ram_waddr   = r_count[AW-1:0];
        ram_wdata   = i_value;
        ram_raddr   = r_scan_addr[AW-1:0];

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (r_count < COUNT_MAX) begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    if (i_last) begin
                        n_state     = ST_SCAN;
                        n_chosen    = '0;
                        n_best      = run_floor;
                        n_scan_addr = '0;
                        n_left      = (r_mode == MODE_ARGMAX) ? TOPCNT_W'(1) : passes;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && (ram_rdata > r_best)) begin
                    n_best   = ram_rdata;
                    n_chosen = r_rd_idx;
                end
                if (r_scan_addr < r_count) begin
                    n_rd_vld    = 1'b1;
                    n_rd_idx    = r_scan_addr[AW-1:0];
                    n_scan_addr = r_scan_addr + CW'(1);
                end else if (!r_rd_vld) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chosen;
                    ram_wdata = FIX_FLOOR;
                    if (r_left == TOPCNT_W'(1)) begin
                        n_state = ST_LOAD;
                        n_count = '0;
                    end else begin
                        n_state     = ST_SCAN;
                        n_left      = r_left - TOPCNT_W'(1);
                        n_best      = run_floor;
                        n_scan_addr = '0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_mode      <= MODE_TOPK;
            r_top_count <= RESET_TOPCNT;
            r_count     <= '0;
            r_chosen    <= '0;
            r_rd_vld    <= 1'b0;
            r_left      <= '0;
            r_scan_addr <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_chosen    <= n_chosen;
            r_rd_vld    <= n_rd_vld;
            r_left      <= n_left;
            r_scan_addr <= n_scan_addr;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:      r_mode      <= i_cfg_data[0];
                    CFG_TOP_COUNT: r_top_count <= i_cfg_data[TOPCNT_W-1:0];
                    default:       r_mode      <= r_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best   <= n_best;
        r_rd_idx <= n_rd_idx;
    end

endmodule
